### sv/clnp_pkg.sv
// ----------------------------------------------------------------------------
// clnp_pkg
// Shared constants, codes and keyword tables for the command line parser.
// ----------------------------------------------------------------------------
package clnp_pkg;

  // Default line length limit; only lines shorter than it decode a keyword
  localparam int MaxLineDefault = 64;

  // Largest argument value
  localparam logic [15:0] ValueMax = 16'hFFFF;

  // Result command codes
  localparam logic [2:0] CmdUnknown = 3'd0;
  localparam logic [2:0] CmdMac     = 3'd1;
  localparam logic [2:0] CmdId      = 3'd2;
  localparam logic [2:0] CmdStatus  = 3'd3;
  localparam logic [2:0] CmdDec     = 3'd4;

  // Keyword slots, one bit each in the alive mask
  localparam int NumKw = 4;

  // Number radix of the argument
  typedef enum logic [1:0] {
    RadixDec = 2'd0,
    RadixOct = 2'd1,
    RadixBin = 2'd2,
    RadixHex = 2'd3
  } radix_e;

  // Characters that matter to the parser
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowB  = 8'h62;
  localparam logic [7:0] ChLowX  = 8'h78;

  // Length of keyword k
  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    unique case (k)
      2'd0:    len = 3'd3;  // mac
      2'd1:    len = 3'd2;  // id
      2'd2:    len = 3'd6;  // status
      default: len = 3'd3;  // dec
    endcase
    return len;
  endfunction

  // Character of keyword k at position pos (zero past its end)
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      2'd0: begin
        unique case (pos)
          3'd0:    ch = "m";
          3'd1:    ch = "a";
          3'd2:    ch = "c";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        unique case (pos)
          3'd0:    ch = "i";
          3'd1:    ch = "d";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        unique case (pos)
          3'd0:    ch = "s";
          3'd1:    ch = "t";
          3'd2:    ch = "a";
          3'd3:    ch = "t";
          3'd4:    ch = "u";
          3'd5:    ch = "s";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0:    ch = "d";
          3'd1:    ch = "e";
          3'd2:    ch = "c";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

### sv/command_line_number_parser_top.sv
// ----------------------------------------------------------------------------
// command_line_number_parser_top
// Decodes a command keyword and a dec, oct, bin or hex unsigned argument, one
// character per item, and gives one result item on the last character of each line.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Moves on
//  s_axis    in   tdata[7:0] char_in, tlast line_end        tvalid & tready
//  m_axis    out  tdata[2:0] command_code,                  tvalid & tready
//                 tdata[18:3] number_value,
//                 tdata[19] argument_error, tdata[23:20] 0
//
//  One character per cycle but for a held line end: an input register, one pass of
//  compare and shift-add logic that updates the line state, and a result register.
//  A result item is registered from the last character in the input register.
//  Reset clears the line state; every result also returns it to reset.
//  A stalled result register holds only the last character of the next
//  line in the input register; other characters keep flowing.
// ----------------------------------------------------------------------------
module command_line_number_parser_top #(
  parameter int MaxLine = clnp_pkg::MaxLineDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] command_code, [18:3] number_value,
                                      // [19] argument_error, [23:20] zero
);
  import clnp_pkg::*;

  localparam int LenW = $clog2(MaxLine + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxLine);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_char_q;
  logic       in_last_q;

  // Line state
  logic            split_q, split_d;
  logic [LenW-1:0] len_q, len_d;
  logic [NumKw-1:0] alive_q, alive_d;
  logic [2:0]      kw_pos_q, kw_pos_d;
  logic [1:0]      arg_pos_q, arg_pos_d;   // saturates at 2
  radix_e          radix_q, radix_d;
  logic [15:0]     acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic            f_digit_q, f_digit_d;
  logic            f_fed_q, f_fed_d;
  logic            f_stray_q, f_stray_d;
  logic            f_zero_q, f_zero_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [19:0] out_data_q, out_data_d;

  logic advance;
  logic out_free;

  // Per-character logic
  logic [7:0]  ch, lc;
  logic        is_blank;
  logic        do_feed;
  radix_e      feed_radix;
  logic [4:0]  digit;
  logic [4:0]  base;
  logic        digit_ok;
  logic [20:0] acc_next;
  logic [2:0]  code;
  logic [15:0] value;
  logic        err;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;

  assign ch       = in_char_q;
  assign lc       = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
  assign is_blank = (ch == ChSpace) || (ch == ChTab);

  // Decode the character as a digit of the feed radix
  always_comb begin
    digit = 5'd31;
    if (ch >= "0" && ch <= "9") begin
      digit = 5'(ch - "0");
    end else if (ch >= "a" && ch <= "f") begin
      digit = 5'(ch - "a") + 5'd10;
    end else if (ch >= "A" && ch <= "F") begin
      digit = 5'(ch - "A") + 5'd10;
    end
    unique case (feed_radix)
      RadixDec: base = 5'd10;
      RadixOct: base = 5'd8;
      RadixBin: base = 5'd2;
      default:  base = 5'd16;
    endcase
    digit_ok = digit < base;
    unique case (feed_radix)
      RadixDec: acc_next = {2'b0, acc_q, 3'b0} + {4'b0, acc_q, 1'b0} + 21'(digit);
      RadixOct: acc_next = {2'b0, acc_q, 3'b0} + 21'(digit);
      RadixBin: acc_next = {4'b0, acc_q, 1'b0} + 21'(digit);
      default:  acc_next = {1'b0, acc_q, 4'b0} + 21'(digit);
    endcase
  end

  // Next line state
  always_comb begin
    split_d   = split_q;
    len_d     = (len_q < LenMax) ? len_q + 1'b1 : len_q;
    alive_d   = alive_q;
    kw_pos_d  = kw_pos_q;
    arg_pos_d = arg_pos_q;
    radix_d   = radix_q;
    acc_d     = acc_q;
    ovf_d     = ovf_q;
    f_digit_d = f_digit_q;
    f_fed_d   = f_fed_q;
    f_stray_d = f_stray_q;
    f_zero_d  = f_zero_q;
    do_feed   = 1'b0;
    feed_radix = radix_q;

    if (!split_q && is_blank) begin
      split_d = 1'b1;
    end else if (!split_q) begin
      // Drop keywords that no longer match
      for (int k = 0; k < NumKw; k++) begin
        if (kw_pos_q >= kw_len(2'(k)) || kw_char(2'(k), kw_pos_q) != lc) begin
          alive_d[k] = 1'b0;
        end
      end
      if (kw_pos_q != 3'd7) begin
        kw_pos_d = kw_pos_q + 3'd1;
      end
    end else begin
      if (arg_pos_q == 2'd0) begin
        if (ch == ChZero) begin
          f_zero_d = 1'b1;
        end else begin
          do_feed = 1'b1;
        end
      end else if (arg_pos_q == 2'd1 && f_zero_q) begin
        // Resolve the prefix after a leading zero
        f_zero_d = 1'b0;
        if (ch == ChLowB) begin
          radix_d = RadixBin;
        end else if (ch == ChLowX) begin
          radix_d = RadixHex;
        end else begin
          radix_d    = RadixOct;
          feed_radix = RadixOct;
          do_feed    = 1'b1;
        end
      end else begin
        do_feed = 1'b1;
      end
      if (arg_pos_q != 2'd2) begin
        arg_pos_d = arg_pos_q + 2'd1;
      end
    end

    // Digit reader: accumulate, skip leading blanks, flag strays and overflow
    if (do_feed) begin
      f_fed_d = 1'b1;
      if (!f_stray_q) begin
        if (digit_ok) begin
          f_digit_d = 1'b1;
          if (!ovf_q) begin
            if (acc_next > 21'(ValueMax)) begin
              ovf_d = 1'b1;
            end else begin
              acc_d = acc_next[15:0];
            end
          end
        end else if (!(is_blank && !f_digit_q)) begin
          f_stray_d = 1'b1;
        end
      end
    end
  end

  // Result from the updated state
  always_comb begin
    code  = CmdUnknown;
    value = 16'd0;
    err   = 1'b0;
    if (len_d < LenMax) begin
      for (int k = 0; k < NumKw; k++) begin
        if (alive_d[k] && kw_pos_d == kw_len(2'(k))) begin
          code = 3'(k + 1);
        end
      end
    end
    if (code == CmdDec) begin
      priority if (f_zero_d) begin
        value = 16'd0;
      end else if ((radix_d == RadixBin || radix_d == RadixHex) && !f_fed_d) begin
        value = 16'd0;
      end else if (f_stray_d || !f_digit_d || ovf_d) begin
        err = 1'b1;
      end else begin
        value = acc_d;
      end
    end
    out_data_d  = {err, value, code};
    out_valid_d = (advance && in_last_q) ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // Line state: advance per item, back to reset after each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q   <= 1'b0;
      len_q     <= '0;
      alive_q   <= '1;
      kw_pos_q  <= 3'd0;
      arg_pos_q <= 2'd0;
      radix_q   <= RadixDec;
      acc_q     <= 16'd0;
      ovf_q     <= 1'b0;
      f_digit_q <= 1'b0;
      f_fed_q   <= 1'b0;
      f_stray_q <= 1'b0;
      f_zero_q  <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        split_q   <= 1'b0;
        len_q     <= '0;
        alive_q   <= '1;
        kw_pos_q  <= 3'd0;
        arg_pos_q <= 2'd0;
        radix_q   <= RadixDec;
        acc_q     <= 16'd0;
        ovf_q     <= 1'b0;
        f_digit_q <= 1'b0;
        f_fed_q   <= 1'b0;
        f_stray_q <= 1'b0;
        f_zero_q  <= 1'b0;
      end else begin
        split_q   <= split_d;
        len_q     <= len_d;
        alive_q   <= alive_d;
        kw_pos_q  <= kw_pos_d;
        arg_pos_q <= arg_pos_d;
        radix_q   <= radix_d;
        acc_q     <= acc_d;
        ovf_q     <= ovf_d;
        f_digit_q <= f_digit_d;
        f_fed_q   <= f_fed_d;
        f_stray_q <= f_stray_d;
        f_zero_q  <= f_zero_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_data_q};

endmodule
